>>> rtl/col_pkg.sv
// ============================================================================
// Circular ordered list package
// Shared types, command and status codes for the circular ordered list engine.
// ============================================================================
package col_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_INS_POS   = 3'd2;
    localparam logic [2:0] CMD_DEL_VAL   = 3'd3;
    localparam logic [2:0] CMD_DEL_POS   = 3'd4;
    localparam logic [2:0] CMD_SEARCH    = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic        [2:0]  cmd;
        logic signed [31:0] value;
        logic        [7:0]  position;
    } col_cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] found_position;
        logic [6:0] length;
    } col_rsp_t;

endpackage

>>> rtl/circular_ordered_list_engine.sv
// ============================================================================
// Circular ordered list engine
// Ordered circular singly linked list of signed values kept in slot memories.
// ============================================================================
// Usage: one command transaction enters on cmd_valid/cmd_stall with fields
// cmd, value and position; exactly one response transaction leaves on
// rsp_valid/rsp_stall with status, found_position and the list length.
// The block holds one command at a time. Front and back inserts pass through
// S_TAKE and then S_WRITE, since the free-list link of a recycled slot is read
// from the link memory first. Searches, deletes and positional inserts walk the
// list one link per S_RD and S_CHK pair, because each link read is registered.
// The walk through the link memory sets the rate.
// Reset clears head, tail, count, free-list head and the never-used counter;
// the memories need no clearing because no slot is read before it is written.
// When the receiver stalls, the response register holds its transaction and
// the next command is taken once the response has been delivered.
// ============================================================================
module circular_ordered_list_engine
    import col_pkg::*;
#(
    parameter int CAPACITY   = col_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = col_pkg::VALUE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  col_pkg::col_cmd_t  cmd_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output col_pkg::col_rsp_t  rsp_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    // Wide enough for both the 8-bit position and the count plus one.
    localparam int PW = (CW + 1 > 9) ? CW + 1 : 9;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TAKE  = 3'd1;   // wait for free-list link read
    localparam logic [2:0] S_WRITE = 3'd2;   // write the new slot
    localparam logic [2:0] S_RD    = 3'd3;   // walk: read issued, wait
    localparam logic [2:0] S_CHK   = 3'd4;   // walk: examine read data
    localparam logic [2:0] S_RSP   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         free_reg, free_next;
    logic [CW-1:0]         used_reg, used_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    col_rsp_t              rsp_reg, rsp_next;

    // Command-scoped registers.
    logic [2:0]            op_reg, op_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [7:0]            pos_reg, pos_next;
    logic [1:0]            mode_reg, mode_next;  // insert kind
    logic [AW-1:0]         slot_reg, slot_next;
    logic [AW-1:0]         prev_reg, prev_next;
    logic [AW-1:0]         cur_reg, cur_next;
    logic [CW-1:0]         idx_reg, idx_next;

    localparam logic [1:0] M_EMPTY = 2'd0;
    localparam logic [1:0] M_FRONT = 2'd1;
    localparam logic [1:0] M_BACK  = 2'd2;
    localparam logic [1:0] M_MID   = 2'd3;

    logic                  val_we, lnk_we, lnk_we2;
    logic [AW-1:0]         val_waddr, lnk_waddr, raddr;
    logic [VALUE_BITS-1:0] val_wdata, val_rdata;
    logic [AW-1:0]         lnk_wdata, lnk_rdata;
    logic [AW-1:0]         lnk_waddr2, lnk_wdata2;
    logic                  second_reg, second_next;  // pending second link write
    logic [AW-1:0]         sec_addr_reg, sec_addr_next;
    logic [AW-1:0]         sec_data_reg, sec_data_next;

    logic [CW-1:0]         cap_c;
    logic [PW-1:0]         pos_w;
    logic                  hit;

    assign cap_c = CW'(CAPACITY);
    assign pos_w = PW'(cmd_data.position);
    assign hit   = (val_rdata == val_reg);

    col_store #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW)
    ) u_store (
        .clk       (clk),
        .val_we    (val_we),
        .val_waddr (val_waddr),
        .val_wdata (val_wdata),
        .lnk_we    (lnk_we),
        .lnk_waddr (lnk_waddr),
        .lnk_wdata (lnk_wdata),
        .raddr     (raddr),
        .val_rdata (val_rdata),
        .lnk_rdata (lnk_rdata)
    );

    assign cmd_stall = (state_reg != S_IDLE) || rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        used_next      = used_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        mode_next      = mode_reg;
        slot_next      = slot_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        second_next    = 1'b0;
        sec_addr_next  = sec_addr_reg;
        sec_data_next  = sec_data_reg;
        val_we         = 1'b0;
        val_waddr      = slot_reg;
        val_wdata      = val_reg;
        lnk_we2        = 1'b0;
        lnk_waddr2     = slot_reg;
        lnk_wdata2     = slot_reg;
        raddr          = cur_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !cmd_stall)
                begin
                    op_next  = cmd_data.cmd;
                    val_next = VALUE_BITS'(cmd_data.value);
                    pos_next = cmd_data.position;
                    rsp_next.status         = ST_OK;
                    rsp_next.found_position = '0;
                    rsp_next.length         = 7'(count_reg);
                    state_next              = S_RSP;
                    prev_next = tail_reg;
                    cur_next  = head_reg;
                    idx_next  = CW'(1);
                    raddr     = head_reg;
                    case (cmd_data.cmd) inside
                        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS:
                        begin
                            raddr = free_reg;
                            if (count_reg >= cap_c)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else if (cmd_data.cmd == CMD_INS_POS && count_reg != '0
                                     && cmd_data.position != 8'd1
                                     && (cmd_data.position == 8'd0
                                         || pos_w > PW'(count_reg) + 1'b1))
                            begin
                                rsp_next.status = ST_RANGE;
                            end
                            else
                            begin
                                if (count_reg == '0)
                                    mode_next = M_EMPTY;
                                else if (cmd_data.cmd == CMD_INS_FRONT
                                         || cmd_data.position == 8'd1
                                            && cmd_data.cmd == CMD_INS_POS)
                                    mode_next = M_FRONT;
                                else if (cmd_data.cmd == CMD_INS_BACK
                                         || pos_w == PW'(count_reg) + 1'b1)
                                    mode_next = M_BACK;
                                else
                                    mode_next = M_MID;
                                state_next = S_TAKE;
                            end
                        end
                        CMD_DEL_VAL, CMD_SEARCH:
                        begin
                            if (count_reg == '0)
                                rsp_next.status = ST_EMPTY;
                            else
                                state_next = S_RD;
                        end
                        CMD_DEL_POS:
                        begin
                            if (count_reg == '0)
                                rsp_next.status = ST_EMPTY;
                            else if (cmd_data.position == 8'd0
                                     || pos_w > PW'(count_reg))
                                rsp_next.status = ST_RANGE;
                            else
                                state_next = S_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_TAKE:
            begin
                // Link memory output now holds next_link[free_head].
                if (used_reg > count_reg)
                begin
                    slot_next = free_reg;
                    free_next = lnk_rdata;
                end
                else
                begin
                    slot_next = used_reg[AW-1:0];
                    used_next = used_reg + 1'b1;
                end
                if (mode_reg == M_MID)
                begin
                    // Walk to the element before the insert point.
                    cur_next = head_reg;
                    idx_next = CW'(1);
                    raddr    = head_reg;
                    state_next = (pos_reg == 8'd2) ? S_WRITE : S_RD;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                val_we    = 1'b1;
                val_waddr = slot_reg;
                lnk_we2   = 1'b1;
                lnk_waddr2 = slot_reg;
                count_next = count_reg + 1'b1;
                unique case (mode_reg)
                    M_EMPTY:
                    begin
                        lnk_wdata2 = slot_reg;
                        head_next  = slot_reg;
                        tail_next  = slot_reg;
                    end
                    M_FRONT, M_BACK:
                    begin
                        lnk_wdata2    = head_reg;
                        second_next   = 1'b1;
                        sec_addr_next = tail_reg;
                        sec_data_next = slot_reg;
                        if (mode_reg == M_BACK)
                            tail_next = slot_reg;
                        else
                            head_next = slot_reg;
                    end
                    default:
                    begin
                        // cur_reg is the predecessor; its link is on the read port.
                        raddr         = cur_reg;
                        lnk_wdata2    = lnk_rdata;
                        second_next   = 1'b1;
                        sec_addr_next = cur_reg;
                        sec_data_next = slot_reg;
                    end
                endcase
                rsp_next.length = 7'(count_next);
                state_next      = S_RSP;
            end

            S_RD:
            begin
                // Read of cur_reg was issued last cycle.
                state_next = S_CHK;
            end

            S_CHK:
            begin
                if (op_reg == CMD_INS_POS)
                begin
                    cur_next = lnk_rdata;
                    idx_next = idx_reg + 1'b1;
                    raddr    = lnk_rdata;
                    state_next = ((CW+1)'(idx_reg) + 2'd2 == (CW+1)'(pos_reg)) ?
                                 S_WRITE : S_RD;
                end
                else if ((op_reg == CMD_DEL_POS && idx_reg == CW'(pos_reg))
                         || (op_reg != CMD_DEL_POS && hit))
                begin
                    state_next = S_RSP;
                    if (op_reg == CMD_SEARCH)
                    begin
                        rsp_next.found_position = 7'(idx_reg);
                    end
                    else
                    begin
                        // Unlink cur from prev and return it to the free list.
                        lnk_we2    = 1'b1;
                        lnk_waddr2 = cur_reg;
                        lnk_wdata2 = free_reg;
                        free_next  = cur_reg;
                        count_next = count_reg - 1'b1;
                        if (count_reg <= CW'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else
                        begin
                            second_next   = 1'b1;
                            sec_addr_next = prev_reg;
                            sec_data_next = lnk_rdata;
                            if (cur_reg == head_reg)
                                head_next = lnk_rdata;
                            if (cur_reg == tail_reg)
                                tail_next = prev_reg;
                        end
                        rsp_next.length = 7'(count_next);
                    end
                end
                else if (idx_reg >= count_reg)
                begin
                    rsp_next.status = ST_NOTFOUND;
                    state_next      = S_RSP;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = lnk_rdata;
                    idx_next  = idx_reg + 1'b1;
                    raddr     = lnk_rdata;
                    state_next = S_RD;
                end
            end

            S_RSP:
            begin
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Port arbitration: a queued second link write goes out the cycle after
    // the first; the sequencer never issues a link write in S_RSP.
    always_comb
    begin
        if (second_reg)
        begin
            lnk_we    = 1'b1;
            lnk_waddr = sec_addr_reg;
            lnk_wdata = sec_data_reg;
        end
        else
        begin
            lnk_we    = lnk_we2;
            lnk_waddr = lnk_waddr2;
            lnk_wdata = lnk_wdata2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            free_reg      <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg      <= rsp_next;
        op_reg       <= op_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        mode_reg     <= mode_next;
        slot_reg     <= slot_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        sec_addr_reg <= sec_addr_next;
        sec_data_reg <= sec_data_next;
    end

    // The second link write always lands in the response cycle.
    a_second_in_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> state_reg == S_RSP)
        else $error("pending link write outside response state");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_c && count_reg <= used_reg)
        else $error("element count exceeds capacity or handed-out slots");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> cmd_stall)
        else $error("command accepted while busy");

    a_rsp_after: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RSP |=> rsp_valid)
        else $error("response not presented");

endmodule

>>> rtl/col_store.sv
// ============================================================================
// Circular ordered list slot store
// Value memory and link memory, one write and one registered read each.
// ============================================================================
module col_store #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32,
    parameter int AW         = 6
) (
    input  logic                  clk,
    input  logic                  val_we,
    input  logic [AW-1:0]         val_waddr,
    input  logic [VALUE_BITS-1:0] val_wdata,
    input  logic                  lnk_we,
    input  logic [AW-1:0]         lnk_waddr,
    input  logic [AW-1:0]         lnk_wdata,
    input  logic [AW-1:0]         raddr,
    output logic [VALUE_BITS-1:0] val_rdata,
    output logic [AW-1:0]         lnk_rdata
);

    logic [VALUE_BITS-1:0] val_mem [CAPACITY];
    logic [AW-1:0]         lnk_mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (lnk_we)
        begin
            lnk_mem[lnk_waddr] <= lnk_wdata;
        end
        val_rdata <= val_mem[raddr];
        lnk_rdata <= lnk_mem[raddr];
    end

endmodule

>>> verif/tb_circular_ordered_list_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// Circular ordered list engine testbench
// Sends insert, delete and search command transactions through the block with
// random gaps and stalls on both channels. A behavioral copy of the list
// predicts every response transaction. Each response is compared field by
// field with the oldest prediction.
// ============================================================================
module tb_circular_ordered_list_engine;
    import col_pkg::*;

    localparam int CAP         = 64;
    localparam int N_RANDOM    = 860;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_DIRECTED  = 24;

    // Command codes that the block does not define.
    localparam logic [2:0] CMD_BAD   = 3'd7;
    localparam logic [2:0] CMD_SPARE = 3'd6;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    col_cmd_t  cmd_data;
    logic      rsp_valid;
    logic      rsp_stall;
    col_rsp_t  rsp_data;

    circular_ordered_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // The clock runs with a 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // The shadow list is kept as a plain queue of values in list order. The
    // slot and link bookkeeping of the block is invisible from outside, so the
    // order of values and the count are all a response can reveal.
    logic signed [31:0] shadow_list[$];
    col_rsp_t           pending_rsp[$];
    int                 fail_count;
    int                 cycle_count;
    bit                 stim_done = 1'b0;

    // Works out the response of one command and updates the shadow list.
    function automatic col_rsp_t apply_command(col_cmd_t c);
        col_rsp_t r;
        int       n;
        int       hit;
        n = shadow_list.size();
        r.status = ST_OK;
        r.found_position = '0;
        hit = -1;
        case (c.cmd)
            CMD_INS_FRONT, CMD_INS_BACK:
            begin
                if (n >= CAP)
                    r.status = ST_FULL;
                else if (c.cmd == CMD_INS_FRONT)
                    shadow_list.push_front(c.value);
                else
                    shadow_list.push_back(c.value);
            end
            CMD_INS_POS:
            begin
                // An empty list takes the value at any position, zero included.
                if (n >= CAP)
                    r.status = ST_FULL;
                else if (n == 0 || c.position == 1)
                    shadow_list.push_front(c.value);
                else if (c.position == 0 || c.position > n + 1)
                    r.status = ST_RANGE;
                else
                    shadow_list.insert(c.position - 1, c.value);
            end
            CMD_DEL_VAL, CMD_SEARCH:
            begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        if (hit < 0 && shadow_list[i] == c.value)
                            hit = i;
                    end
                    if (hit < 0)
                        r.status = ST_NOTFOUND;
                    else if (c.cmd == CMD_SEARCH)
                        r.found_position = 7'(hit + 1);
                    else
                        shadow_list.delete(hit);
                end
            end
            CMD_DEL_POS:
            begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else if (c.position == 0 || c.position > n)
                    r.status = ST_RANGE;
                else
                    shadow_list.delete(c.position - 1);
            end
            default:
            begin
                // Unknown commands leave the list alone and report ok.
            end
        endcase
        r.length = 7'(shadow_list.size());
        return r;
    endfunction

    // Random gap length: mostly short, now and then long, often none.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // Picks a value: mostly from a small pool so that searches and deletes
    // hit, sometimes fully random, sometimes an extreme.
    function automatic logic signed [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 32'($signed($urandom_range(0, 15)) - 8);
        else if (roll < 90)
            return $urandom();
        else if (roll < 95)
            return 32'sh7FFF_FFFF;
        else
            return 32'sh8000_0000;
    endfunction

    // Builds one random command. The mix drifts with the fill or drain phase so that
    // the run visits both the empty and the full store many times.
    function automatic col_cmd_t pick_command(int phase_fill);
        col_cmd_t c;
        int       n;
        int       roll;
        n = shadow_list.size();
        roll = $urandom_range(0, 99);
        if (roll < (phase_fill ? 55 : 25))
            c.cmd = 3'($urandom_range(0, 2));
        else if (roll < 97)
            c.cmd = 3'($urandom_range(3, 5));
        else
            c.cmd = 3'($urandom_range(6, 7));
        c.value = pick_value();
        roll = $urandom_range(0, 99);
        if (roll < 75)
            c.position = 8'($urandom_range(1, n + 1));
        else if (roll < 85)
            c.position = 8'(n + 1 + $urandom_range(0, 2));
        else if (roll < 92)
            c.position = 8'd0;
        else
            c.position = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Directed rows: a command and, where it is obvious, the response that
    // must come back. Rows with check_fixed clear are checked by prediction.
    typedef struct {
        col_cmd_t c;
        bit       check_fixed;
        col_rsp_t r;
    } directed_row_t;

    directed_row_t directed_rows[N_DIRECTED];

    initial
    begin
        directed_rows[0]  = '{'{CMD_SEARCH, 32'sd5, 8'd0}, 1'b1, '{ST_EMPTY, 7'd0, 7'd0}};
        directed_rows[1]  = '{'{CMD_DEL_VAL, 32'sd5, 8'd0}, 1'b1, '{ST_EMPTY, 7'd0, 7'd0}};
        directed_rows[2]  = '{'{CMD_DEL_POS, 32'sd0, 8'd1}, 1'b1, '{ST_EMPTY, 7'd0, 7'd0}};
        directed_rows[3]  = '{'{CMD_INS_POS, 32'sh7FFF_FFFF, 8'd0}, 1'b1,
                              '{ST_OK, 7'd0, 7'd1}};
        directed_rows[4]  = '{'{CMD_INS_FRONT, 32'sh8000_0000, 8'd0}, 1'b1,
                              '{ST_OK, 7'd0, 7'd2}};
        directed_rows[5]  = '{'{CMD_INS_BACK, 32'sd0, 8'd255}, 1'b1, '{ST_OK, 7'd0, 7'd3}};
        directed_rows[6]  = '{'{CMD_SEARCH, 32'sh8000_0000, 8'd0}, 1'b1,
                              '{ST_OK, 7'd1, 7'd3}};
        directed_rows[7]  = '{'{CMD_SEARCH, 32'sd0, 8'd0}, 1'b1, '{ST_OK, 7'd3, 7'd3}};
        directed_rows[8]  = '{'{CMD_SEARCH, -32'sd1, 8'd0}, 1'b1,
                              '{ST_NOTFOUND, 7'd0, 7'd3}};
        directed_rows[9]  = '{'{CMD_INS_POS, 32'sd9, 8'd0}, 1'b1, '{ST_RANGE, 7'd0, 7'd3}};
        directed_rows[10] = '{'{CMD_INS_POS, 32'sd9, 8'd5}, 1'b1, '{ST_RANGE, 7'd0, 7'd3}};
        directed_rows[11] = '{'{CMD_INS_POS, 32'sd9, 8'd255}, 1'b1,
                              '{ST_RANGE, 7'd0, 7'd3}};
        directed_rows[12] = '{'{CMD_INS_POS, 32'sd7, 8'd2}, 1'b0, '{ST_OK, 7'd0, 7'd0}};
        directed_rows[13] = '{'{CMD_INS_POS, 32'sd8, 8'd5}, 1'b0, '{ST_OK, 7'd0, 7'd0}};
        directed_rows[14] = '{'{CMD_DEL_POS, 32'sd0, 8'd0}, 1'b1, '{ST_RANGE, 7'd0, 7'd5}};
        directed_rows[15] = '{'{CMD_DEL_POS, 32'sd0, 8'd6}, 1'b1, '{ST_RANGE, 7'd0, 7'd5}};
        directed_rows[16] = '{'{CMD_DEL_VAL, 32'sd1234, 8'd0}, 1'b1,
                              '{ST_NOTFOUND, 7'd0, 7'd5}};
        directed_rows[17] = '{'{CMD_BAD, 32'sd0, 8'd0}, 1'b1, '{ST_OK, 7'd0, 7'd5}};
        directed_rows[18] = '{'{CMD_SPARE, 32'sd0, 8'd3}, 1'b1, '{ST_OK, 7'd0, 7'd5}};
        directed_rows[19] = '{'{CMD_DEL_POS, 32'sd0, 8'd5}, 1'b0, '{ST_OK, 7'd0, 7'd0}};
        directed_rows[20] = '{'{CMD_DEL_POS, 32'sd0, 8'd1}, 1'b0, '{ST_OK, 7'd0, 7'd0}};
        directed_rows[21] = '{'{CMD_DEL_VAL, 32'sd7, 8'd0}, 1'b0, '{ST_OK, 7'd0, 7'd0}};
        directed_rows[22] = '{'{CMD_DEL_VAL, 32'sh8000_0000, 8'd0}, 1'b0,
                              '{ST_OK, 7'd0, 7'd0}};
        directed_rows[23] = '{'{CMD_SEARCH, 32'sh7FFF_FFFF, 8'd0}, 1'b0,
                              '{ST_OK, 7'd0, 7'd0}};
    end

    // Drives one command transaction and holds it until it is accepted. The
    // prediction is made here, in the order the block takes commands, so the
    // expected-response queue stays in step with the response channel. Valid
    // stays high after acceptance when the next command follows at once.
    task automatic send_command(col_cmd_t c, bit check_fixed, col_rsp_t fixed_rsp);
        col_rsp_t predicted;
        int       gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predicted = apply_command(c);
        if (check_fixed && predicted != fixed_rsp)
        begin
            $error("directed row prediction disagrees: expected %h, predicted %h",
                   fixed_rsp, predicted);
            fail_count++;
        end
        pending_rsp.push_back(check_fixed ? fixed_rsp : predicted);
    endtask

    // Command side: reset, the directed table, a fill to capacity, then random
    // traffic in phases that alternately fill and drain the store.
    initial
    begin
        col_rsp_t none;
        none = '0;
        fail_count = 0;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_data  = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_command(directed_rows[i].c, directed_rows[i].check_fixed,
                         directed_rows[i].r);

        // Fill to capacity once with straight inserts so the full check is
        // reached early, then try every insert form against the full store.
        while (shadow_list.size() < CAP)
            send_command('{3'($urandom_range(0, 2)), pick_value(), 8'd1}, 1'b0, none);
        send_command('{CMD_INS_FRONT, 32'sd1, 8'd0}, 1'b1, '{ST_FULL, 7'd0, 7'(CAP)});
        send_command('{CMD_INS_BACK, 32'sd1, 8'd0}, 1'b1, '{ST_FULL, 7'd0, 7'(CAP)});
        send_command('{CMD_INS_POS, 32'sd1, 8'd255}, 1'b1, '{ST_FULL, 7'd0, 7'(CAP)});
        send_command('{CMD_DEL_POS, 32'sd0, 8'(CAP)}, 1'b0, none);

        for (int i = 0; i < N_RANDOM; i++)
            send_command(pick_command((i / 150) % 2 == 0), 1'b0, none);
        cmd_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Response side: random stalls, mostly short, with an occasional long run.
    initial
    begin
        int stall_run;
        int roll;
        stall_run = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_run > 0)
            begin
                stall_run--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                begin
                    stall_run = $urandom_range(10, 60);
                    rsp_stall <= 1'b1;
                end
                else if (roll < 25)
                    rsp_stall <= 1'b1;
                else
                    rsp_stall <= 1'b0;
            end
        end
    end

    // Response checker: every accepted response transaction is matched with
    // the oldest prediction, field by field.
    always @(posedge clk)
    begin
        col_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with no command outstanding: %h", rsp_data);
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_data.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, rsp_data.status);
                    fail_count++;
                end
                if (rsp_data.found_position !== want.found_position)
                begin
                    $error("found_position mismatch: expected %0d, actual %0d",
                           want.found_position, rsp_data.found_position);
                    fail_count++;
                end
                if (rsp_data.length !== want.length)
                begin
                    $error("length mismatch: expected %0d, actual %0d",
                           want.length, rsp_data.length);
                    fail_count++;
                end
            end
        end
    end

    // Completion and watchdog. The run ends once the last command has been
    // taken and every response has arrived, plus a short drain period in
    // which a stray extra response would still be caught.
    initial
    begin
        int drain;
        cycle_count = 0;
        drain = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else if (stim_done && pending_rsp.size() == 0)
                drain++;
            else
                drain = 0;
            if (drain > 2 * CAP + 40)
            begin
                if (fail_count == 0)
                    $display("Verification passed");
                else
                    $display("Verification failed");
                $finish;
            end
        end
    end

endmodule

>>> circular_ordered_list_engine.f
rtl/col_pkg.sv
rtl/col_store.sv
rtl/circular_ordered_list_engine.sv
verif/tb_circular_ordered_list_engine.sv
